@@ src/tdbs_pkg.sv @@
// Package for the two-wire display bus sequencer.
// Holds the command kinds, the sequencer state type and the phase numbers.
// No dependencies.
`default_nettype none

package tdbs_pkg;

  // Command currently running on the bus.
  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  // Command codes as they arrive on the input word.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  // Reserved code; the sequencer never takes it.
  localparam logic [1:0] CMD_BAD   = 2'd3;

  // Phase counter width and the phases of each command.
  localparam int unsigned STAGE_W = 5;
  typedef logic [STAGE_W-1:0] stage_t;

  localparam stage_t ST_0 = 5'd0;
  localparam stage_t ST_1 = 5'd1;
  localparam stage_t ST_2 = 5'd2;
  localparam stage_t ST_3 = 5'd3;

  // Write: sixteen bit phases, then release, wait for ack, pulse, finish.
  localparam stage_t BIT_PHASES  = 5'd16;
  localparam stage_t ST_W_REL    = 5'd16;
  localparam stage_t ST_W_ACK    = 5'd17;
  localparam stage_t ST_W_PULSE  = 5'd18;
  localparam stage_t ST_W_FINISH = 5'd19;

endpackage : tdbs_pkg

`default_nettype wire

@@ src/tdbs_in_if.sv @@
// Input channel of the bus sequencer: one bus phase tick per word.
// Carries valid, ready and the command fields. No dependencies.
`default_nettype none

interface tdbs_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic       dat_sample;

  modport source (output valid, output cmd_valid, output operation,
                  output data_byte, output dat_sample, input ready);
  modport sink   (input valid, input cmd_valid, input operation,
                  input data_byte, input dat_sample, output ready);
endinterface : tdbs_in_if

`default_nettype wire

@@ src/tdbs_out_if.sv @@
// Result channel of the bus sequencer: the line levels and status after a tick.
// Carries valid, ready and the result fields. No dependencies.
`default_nettype none

interface tdbs_out_if;
  logic valid;
  logic ready;
  logic clk_out;
  logic dat_out;
  logic dat_drive;
  logic busy_res;
  logic accepted;
  logic ack_seen;

  modport source (output valid, output clk_out, output dat_out, output dat_drive,
                  output busy_res, output accepted, output ack_seen, input ready);
  modport sink   (input valid, input clk_out, input dat_out, input dat_drive,
                  input busy_res, input accepted, input ack_seen, output ready);
endinterface : tdbs_out_if

`default_nettype wire

@@ src/two_wire_display_bus_sequencer_top.sv @@
// The result word of a tick is registered and valid in the cycle after the input word is taken.
// Throughput: one word per cycle while the output is read; the single output register is refilled in the
// same cycle it is read, and the phase state updates once per accepted word.
// Reset (rst_n low, synchronous): idle, both lines high, data driven, no result held.
// Depends on tdbs_pkg, tdbs_in_if and tdbs_out_if.
`default_nettype none

module two_wire_display_bus_sequencer_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  tdbs_in_if.sink         in_bus,
  tdbs_out_if.source      out_bus
);

  // Sequencer state.
  tdbs_pkg::op_t    op_r, op_nxt;
  tdbs_pkg::stage_t stage_r, stage_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             clk_lvl_r, clk_lvl_nxt;
  logic             dat_lvl_r, dat_lvl_nxt;
  logic             dat_en_r, dat_en_nxt;

  // Output register.
  logic out_valid_r;
  logic clk_out_r, dat_out_r, dat_drive_r, busy_r, accepted_r, ack_r;

  // Values after taking a command, before running the phase.
  logic             take;
  logic             ack_nxt;
  logic             in_fire;
  tdbs_pkg::op_t    eff_op;
  tdbs_pkg::stage_t eff_stage;

  // A new word fits when the output register is empty or being read.
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_fire      = in_bus.valid && in_bus.ready;

  // Command intake: only while idle and only for a known code.
  always_comb begin
    take      = (op_r == tdbs_pkg::OP_IDLE) && in_bus.cmd_valid &&
                (in_bus.operation != tdbs_pkg::CMD_BAD);
    eff_op    = op_r;
    eff_stage = stage_r;
    byte_nxt  = byte_r;
    if (take) begin
      eff_stage = tdbs_pkg::ST_0;
      unique case (in_bus.operation)
        tdbs_pkg::CMD_START: eff_op = tdbs_pkg::OP_START;
        tdbs_pkg::CMD_STOP:  eff_op = tdbs_pkg::OP_STOP;
        default: begin
          eff_op   = tdbs_pkg::OP_WRITE;
          byte_nxt = in_bus.data_byte;
        end
      endcase
    end
  end

  // Next command and phase.
  always_comb begin
    op_nxt    = eff_op;
    stage_nxt = eff_stage;
    unique case (eff_op)
      tdbs_pkg::OP_START: begin
        if (eff_stage == tdbs_pkg::ST_0) begin
          stage_nxt = tdbs_pkg::ST_1;
        end else begin
          op_nxt = tdbs_pkg::OP_IDLE;
        end
      end
      tdbs_pkg::OP_STOP: begin
        if (eff_stage < tdbs_pkg::ST_3) begin
          stage_nxt = eff_stage + tdbs_pkg::ST_1;
        end else begin
          op_nxt = tdbs_pkg::OP_IDLE;
        end
      end
      tdbs_pkg::OP_WRITE: begin
        if (eff_stage < tdbs_pkg::BIT_PHASES) begin
          stage_nxt = eff_stage + tdbs_pkg::ST_1;
        end else begin
          unique case (eff_stage)
            tdbs_pkg::ST_W_REL:   stage_nxt = tdbs_pkg::ST_W_ACK;
            tdbs_pkg::ST_W_ACK: begin
              if (!in_bus.dat_sample) begin
                stage_nxt = tdbs_pkg::ST_W_PULSE;
              end
            end
            tdbs_pkg::ST_W_PULSE: stage_nxt = tdbs_pkg::ST_W_FINISH;
            default:              op_nxt = tdbs_pkg::OP_IDLE;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Line levels and acknowledge flag for this phase.
  always_comb begin
    clk_lvl_nxt = clk_lvl_r;
    dat_lvl_nxt = dat_lvl_r;
    dat_en_nxt  = dat_en_r;
    ack_nxt     = 1'b0;
    unique case (eff_op)
      tdbs_pkg::OP_START: begin
        if (eff_stage == tdbs_pkg::ST_0) begin
          clk_lvl_nxt = 1'b1;
          dat_lvl_nxt = 1'b1;
        end else if (eff_stage == tdbs_pkg::ST_1) begin
          dat_lvl_nxt = 1'b0;
        end
      end
      tdbs_pkg::OP_STOP: begin
        unique case (eff_stage)
          tdbs_pkg::ST_0: clk_lvl_nxt = 1'b0;
          tdbs_pkg::ST_1: dat_lvl_nxt = 1'b0;
          tdbs_pkg::ST_2: clk_lvl_nxt = 1'b1;
          tdbs_pkg::ST_3: dat_lvl_nxt = 1'b1;
          default: ;
        endcase
      end
      tdbs_pkg::OP_WRITE: begin
        if (eff_stage < tdbs_pkg::BIT_PHASES) begin
          // Odd phases raise the clock; even phases lower it and set the next bit.
          if (eff_stage[0]) begin
            clk_lvl_nxt = 1'b1;
          end else begin
            clk_lvl_nxt = 1'b0;
            dat_lvl_nxt = byte_nxt[eff_stage[3:1]];
          end
        end else begin
          unique case (eff_stage)
            tdbs_pkg::ST_W_REL: begin
              dat_en_nxt  = 1'b0;
              clk_lvl_nxt = 1'b0;
            end
            tdbs_pkg::ST_W_ACK:   ack_nxt = !in_bus.dat_sample;
            tdbs_pkg::ST_W_PULSE: clk_lvl_nxt = 1'b1;
            tdbs_pkg::ST_W_FINISH: begin
              clk_lvl_nxt = 1'b0;
              dat_en_nxt  = 1'b1;
              dat_lvl_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // State registers advance once per accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r      <= tdbs_pkg::OP_IDLE;
      stage_r   <= tdbs_pkg::ST_0;
      byte_r    <= 8'd0;
      clk_lvl_r <= 1'b1;
      dat_lvl_r <= 1'b1;
      dat_en_r  <= 1'b1;
    end else if (in_fire) begin
      op_r      <= op_nxt;
      stage_r   <= stage_nxt;
      byte_r    <= byte_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      dat_lvl_r <= dat_lvl_nxt;
      dat_en_r  <= dat_en_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      clk_out_r   <= clk_lvl_nxt;
      dat_out_r   <= dat_en_nxt & dat_lvl_nxt;
      dat_drive_r <= dat_en_nxt;
      busy_r      <= (op_nxt != tdbs_pkg::OP_IDLE);
      accepted_r  <= take;
      ack_r       <= ack_nxt;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.clk_out   = clk_out_r;
  assign out_bus.dat_out   = dat_out_r;
  assign out_bus.dat_drive = dat_drive_r;
  assign out_bus.busy_res  = busy_r;
  assign out_bus.accepted  = accepted_r;
  assign out_bus.ack_seen  = ack_r;

`ifndef SYNTHESIS
  // An acknowledge is only seen with data released and the write still running.
  a_ack_released: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ack_r) |-> (!dat_drive_r && busy_r))
    else $error("acknowledge reported while data is driven or idle");

  // Data is released only in the middle of a write.
  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !dat_drive_r) |-> busy_r)
    else $error("data line released while no command runs");

  // The state does not move while a word is stalled at the output.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |=> ($stable(op_r) && $stable(stage_r)))
    else $error("sequencer advanced while the result was stalled");
`endif

endmodule : two_wire_display_bus_sequencer_top

`default_nettype wire
